[rtl/core/swft_pkg.sv]
`timescale 1ns / 1ps
package swft_pkg;

	// Width of one text character.
	localparam int CHAR_W = 8;

	// Default longest run of characters held back before pass-through.
	localparam int MAX_STOP_LEN_DEFAULT = 5;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Longest stopword in the list; a key packs that many characters.
	localparam int STOP_MAX_LEN = 5;
	localparam int STOP_KEY_W = STOP_MAX_LEN * CHAR_W;
	localparam int STOP_COUNT = 73;

	// Stopwords, right-aligned: the last character sits in the lowest byte.
	localparam logic [STOP_KEY_W-1:0] STOP_WORDS [STOP_COUNT] = '{
		40'("a"), 40'("an"), 40'("and"), 40'("are"), 40'("as"),
		40'("at"), 40'("be"), 40'("by"), 40'("for"), 40'("from"),
		40'("has"), 40'("he"), 40'("in"), 40'("is"), 40'("it"),
		40'("its"), 40'("of"), 40'("on"), 40'("that"), 40'("the"),
		40'("to"), 40'("was"), 40'("will"), 40'("with"), 40'("this"),
		40'("but"), 40'("they"), 40'("have"), 40'("had"), 40'("what"),
		40'("said"), 40'("each"), 40'("which"), 40'("their"), 40'("time"),
		40'("if"), 40'("up"), 40'("out"), 40'("many"), 40'("then"),
		40'("them"), 40'("these"), 40'("so"), 40'("some"), 40'("her"),
		40'("would"), 40'("make"), 40'("like"), 40'("into"), 40'("him"),
		40'("two"), 40'("more"), 40'("very"), 40'("after"), 40'("words"),
		40'("long"), 40'("than"), 40'("first"), 40'("been"), 40'("call"),
		40'("who"), 40'("oil"), 40'("sit"), 40'("now"), 40'("find"),
		40'("down"), 40'("day"), 40'("did"), 40'("get"), 40'("come"),
		40'("made"), 40'("may"), 40'("part")
	};

	// A key holds only non-zero characters, so equal keys mean equal words
	// of equal length.
	function automatic logic is_stopword(input logic [STOP_KEY_W-1:0] key);
		logic hit;
		hit = 1'b0;
		for (int w = 0; w < STOP_COUNT; w++) begin
			if (key == STOP_WORDS[w]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

[rtl/core/swft_front.sv]
`timescale 1ns / 1ps
module swft_front #(
	parameter int MAX_STOP_LEN = swft_pkg::MAX_STOP_LEN_DEFAULT,
	parameter int DESC_W = (MAX_STOP_LEN + 1) * swft_pkg::CHAR_W
		+ $clog2(MAX_STOP_LEN + 2) + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [swft_pkg::CHAR_W-1:0]  in_byte,
	input  logic                         in_end,
	output logic                         enq_valid,
	input  logic                         enq_ready,
	output logic [DESC_W-1:0]            enq_data
);
	import swft_pkg::*;

	localparam int CNT_W = $clog2(MAX_STOP_LEN + 1);
	localparam int DCNT_W = $clog2(MAX_STOP_LEN + 2);

	logic [MAX_STOP_LEN-1:0][CHAR_W-1:0] held_q;
	logic [STOP_KEY_W-1:0]               key_q;
	logic [CNT_W-1:0]                    held_count_q;
	logic                                long_q;

	logic                                accept;
	logic [CHAR_W-1:0]                   c;
	logic                                tok;
	logic [STOP_KEY_W-1:0]               key_next;
	logic [MAX_STOP_LEN:0][CHAR_W-1:0]   d_chars;
	logic [DCNT_W-1:0]                   d_cnt;
	logic                                d_present;
	logic                                d_eot;
	logic                                d_push;
	logic                                held_full;

	// Queue space alone decides acceptance.
	assign in_ready = enq_ready;
	assign accept = in_valid && in_ready;

	// Lowercase and classify the incoming beat.
	always_comb begin
		c = in_byte;
		if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
			c = in_byte + 8'h20;
		end
		tok = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
	end

	assign held_full = (held_count_q == CNT_W'(MAX_STOP_LEN));

	// The running key restarts with the first character of a token.
	assign key_next = (held_count_q == '0) ? STOP_KEY_W'(c)
		: {key_q[STOP_KEY_W-CHAR_W-1:0], c};

	// Held characters with the current one placed after them.
	always_comb begin
		for (int i = 0; i < MAX_STOP_LEN; i++) begin
			d_chars[i] = (tok && held_count_q == CNT_W'(i)) ? c : held_q[i];
		end
		d_chars[MAX_STOP_LEN] = c;
	end

	// Classify the beat into a burst for the back end.
	always_comb begin
		d_cnt = DCNT_W'(1);
		d_present = 1'b1;
		d_eot = 1'b1;
		d_push = 1'b0;
		priority if (tok && long_q) begin
			d_eot = in_end;
			d_push = 1'b1;
		end else if (tok && !held_full) begin
			d_cnt = DCNT_W'(held_count_q) + DCNT_W'(1);
			d_push = in_end && !((d_cnt <= DCNT_W'(STOP_MAX_LEN))
				&& is_stopword(key_next));
		end else if (tok) begin
			d_cnt = DCNT_W'(MAX_STOP_LEN + 1);
			d_eot = in_end;
			d_push = 1'b1;
		end else if (long_q) begin
			d_present = 1'b0;
			d_push = 1'b1;
		end else begin
			d_cnt = DCNT_W'(held_count_q);
			d_push = (held_count_q != '0) && !((held_count_q <= CNT_W'(STOP_MAX_LEN))
				&& is_stopword(key_q));
		end
	end

	assign enq_valid = accept && d_push;
	assign enq_data = {d_eot, d_present, d_cnt, d_chars};

	// Token state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			long_q <= 1'b0;
		end else if (accept) begin
			priority if (tok && long_q) begin
				long_q <= !in_end;
			end else if (tok && !held_full) begin
				held_count_q <= in_end ? '0 : held_count_q + CNT_W'(1);
			end else if (tok) begin
				held_count_q <= '0;
				long_q <= !in_end;
			end else begin
				held_count_q <= '0;
				long_q <= 1'b0;
			end
		end
	end

	// Held characters and the stopword key.
	always_ff @(posedge clk) begin
		if (accept && tok && !long_q && !held_full) begin
			for (int i = 0; i < MAX_STOP_LEN; i++) begin
				if (held_count_q == CNT_W'(i)) begin
					held_q[i] <= c;
				end
			end
			key_q <= key_next;
		end
	end

	a_long_empty: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> held_count_q == '0)
		else $error("characters held during pass-through");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(MAX_STOP_LEN))
		else $error("held count out of range");

endmodule

[rtl/core/swft_queue.sv]
`timescale 1ns / 1ps
module swft_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = swft_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             not_full,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_empty,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data
);
	import swft_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];

	// Pointers and fill count; pointers wrap at the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("read from an empty queue");

endmodule

[rtl/core/swft_back.sv]
`timescale 1ns / 1ps
module swft_back #(
	parameter int MAX_STOP_LEN = swft_pkg::MAX_STOP_LEN_DEFAULT,
	parameter int DESC_W = (MAX_STOP_LEN + 1) * swft_pkg::CHAR_W
		+ $clog2(MAX_STOP_LEN + 2) + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  logic [DESC_W-1:0]            head_data,
	output logic                         head_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [swft_pkg::CHAR_W-1:0]  m_tdata,
	output logic [1:0]                   m_tuser,
	output logic                         m_tlast
);
	import swft_pkg::*;

	localparam int DCNT_W = $clog2(MAX_STOP_LEN + 2);
	localparam int CHARS_W = (MAX_STOP_LEN + 1) * CHAR_W;

	logic [MAX_STOP_LEN:0][CHAR_W-1:0] h_chars;
	logic [DCNT_W-1:0]                 h_cnt;
	logic                              h_present;
	logic                              h_eot;
	logic [DCNT_W-1:0]                 idx_q;
	logic                              out_free;
	logic                              step;
	logic                              last;
	logic [CHAR_W-1:0]                 sel_byte;
	logic                              m_tvalid_q;
	logic [CHAR_W-1:0]                 m_tdata_q;
	logic [1:0]                        m_tuser_q;
	logic                              m_tlast_q;

	assign h_chars = head_data[CHARS_W-1:0];
	assign h_cnt = head_data[CHARS_W +: DCNT_W];
	assign h_present = head_data[CHARS_W + DCNT_W];
	assign h_eot = head_data[CHARS_W + DCNT_W + 1];

	assign out_free = !m_tvalid_q || m_tready;
	assign step = out_free && head_valid;
	assign last = (idx_q == h_cnt - DCNT_W'(1));
	assign head_pop = step && last;

	// Pick the character of the burst under the index.
	always_comb begin
		sel_byte = '0;
		for (int i = 0; i <= MAX_STOP_LEN; i++) begin
			if (idx_q == DCNT_W'(i)) begin
				sel_byte = h_chars[i];
			end
		end
	end

	// Burst position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (step) begin
			idx_q <= last ? '0 : idx_q + DCNT_W'(1);
		end
	end

	// Output register: holds a beat while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= h_present ? sel_byte : '0;
			m_tuser_q <= {h_eot && last, h_present};
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q[1] |-> m_tlast_q)
		else $error("token end not on the last beat of a burst");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < h_cnt)
		else $error("burst index beyond burst length");

endmodule

[rtl/core/stopword_filtering_tokenizer.sv]
`timescale 1ns / 1ps
// Channel  Dir  tdata          tuser                           tlast
// s_*      in   text_byte      -                               end_of_text
// m_*      out  out_byte       byte_present, end_of_token      last_of_run
//
// One text beat is taken per cycle while the burst queue has room.
// A beat causes 0 to MAX_STOP_LEN+1 output beats, sent one per cycle by the
// back end while the sink is ready; a flushed token of n characters gives n output beats.
// Reset clears held-token state, the queue and the output register.
// An output stall fills the queue; input stalls only when the queue is full.
module stopword_filtering_tokenizer #(
	parameter int MAX_STOP_LEN = swft_pkg::MAX_STOP_LEN_DEFAULT,
	parameter int QUEUE_DEPTH = swft_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [swft_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] text_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [swft_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]                   m_tuser,   // [0] byte_present, [1] end_of_token
	output logic                         m_tlast
);
	import swft_pkg::*;

	localparam int DESC_W = (MAX_STOP_LEN + 1) * CHAR_W + $clog2(MAX_STOP_LEN + 2) + 2;

	logic              enq_valid;
	logic              enq_ready;
	logic [DESC_W-1:0] enq_data;
	logic              head_valid;
	logic              head_pop;
	logic [DESC_W-1:0] head_data;

	// Classifier and token holder.
	swft_front #(
		.MAX_STOP_LEN(MAX_STOP_LEN),
		.DESC_W(DESC_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_end(s_tlast),
		.enq_valid(enq_valid),
		.enq_ready(enq_ready),
		.enq_data(enq_data)
	);

	// Burst queue.
	swft_queue #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(enq_valid),
		.not_full(enq_ready),
		.push_data(enq_data),
		.not_empty(head_valid),
		.pop(head_pop),
		.head_data(head_data)
	);

	// Burst serialiser.
	swft_back #(
		.MAX_STOP_LEN(MAX_STOP_LEN),
		.DESC_W(DESC_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.head_pop(head_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
